FILE: src/fcs_pkg.sv
// fcs_pkg: types and constants shared by the frontier cell stencil block.
// Holds field widths, register indexes and the transaction payload structs.
// No dependencies.
package fcs_pkg;

   localparam int OCC_W      = 8;
   localparam int COORD_W    = 10;
   localparam int CNT_W      = 21;
   localparam int SIZE_W     = 11;
   localparam int THR_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FREE_THR   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EIGHT_CONN = 2'd3;

   localparam logic [SIZE_W-1:0] MAP_WIDTH_RESET  = 11'd1024;
   localparam logic [SIZE_W-1:0] MAP_HEIGHT_RESET = 11'd1024;
   localparam logic [THR_W-1:0]  FREE_THR_RESET   = 7'd25;

   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [SIZE_W-1:0] map_width;
      logic [SIZE_W-1:0] map_height;
      logic [THR_W-1:0]  free_threshold;
      logic              eight_connectivity;
   } cfg_type;

   typedef struct packed {
      logic                    cmd;
      logic signed [OCC_W-1:0] occupancy;
      logic                    inflated;
      logic                    reachable;
   } item_type;

   typedef struct packed {
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic               frontier;
      logic               frontier_eligible;
      logic               frontier_reachable;
      logic [CNT_W-1:0]   raw_count;
      logic [CNT_W-1:0]   eligible_count;
      logic [CNT_W-1:0]   reachable_count;
      logic [CNT_W-1:0]   unknown_count;
      logic               last;
   } result_type;

   typedef struct packed {
      logic       a_valid;
      logic       b_valid;
      result_type a;
      result_type b;
   } pair_type;

endpackage

FILE: src/fcs_if.sv
// fcs_if: valid/ready channel interfaces for cells, results and register writes.
// Depends on fcs_pkg for field widths.
interface fcs_req_if;
   import fcs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic signed [OCC_W-1:0] occupancy;
   logic                    inflated;
   logic                    reachable;
   modport source (output valid, output cmd, output occupancy, output inflated,
                   output reachable, input ready);
   modport sink (input valid, input cmd, input occupancy, input inflated,
                 input reachable, output ready);
endinterface

interface fcs_rsp_if;
   import fcs_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] cell_x;
   logic [COORD_W-1:0] cell_y;
   logic               frontier;
   logic               frontier_eligible;
   logic               frontier_reachable;
   logic [CNT_W-1:0]   raw_count;
   logic [CNT_W-1:0]   eligible_count;
   logic [CNT_W-1:0]   reachable_count;
   logic [CNT_W-1:0]   unknown_count;
   logic               last;
   modport source (output valid, output cell_x, output cell_y, output frontier,
                   output frontier_eligible, output frontier_reachable,
                   output raw_count, output eligible_count, output reachable_count,
                   output unknown_count, output last, input ready);
   modport sink (input valid, input cell_x, input cell_y, input frontier,
                 input frontier_eligible, input frontier_reachable,
                 input raw_count, input eligible_count, input reachable_count,
                 input unknown_count, input last, output ready);
endinterface

interface fcs_csr_if;
   import fcs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/fcs_line_ram.sv
// fcs_line_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcs_line_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: src/fcs_result_queue.sv
// fcs_result_queue: small result queue taking up to two results a cycle and
// presenting one per transaction on the result channel. Depends on fcs_pkg, fcs_if.
module fcs_result_queue (
   input  logic              clock,
   input  logic              reset,
   input  fcs_pkg::pair_type pair,
   output logic              room_ok,
   fcs_rsp_if.source         rsp_bus
);
   import fcs_pkg::*;

   result_type           slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [1:0]           n_push;
   logic                 pop;
   result_type           first;
   result_type           head;

   assign n_push  = {1'b0, pair.a_valid} + {1'b0, pair.b_valid};
   assign first   = pair.a_valid ? pair.a : pair.b;
   assign pop     = rsp_bus.valid && rsp_bus.ready;
   assign room_ok = count_ff <= RSP_CNT_W'(RSP_DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_CNT_W'(n_push) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         slot_ff[wr_ptr_ff] <= first;
      end
      if (n_push == 2'd2) begin
         slot_ff[wr_ptr_ff + 1'b1] <= pair.b;
      end
   end

   assign head                       = slot_ff[rd_ptr_ff];
   assign rsp_bus.valid              = count_ff != '0;
   assign rsp_bus.cell_x             = head.cell_x;
   assign rsp_bus.cell_y             = head.cell_y;
   assign rsp_bus.frontier           = head.frontier;
   assign rsp_bus.frontier_eligible  = head.frontier_eligible;
   assign rsp_bus.frontier_reachable = head.frontier_reachable;
   assign rsp_bus.raw_count          = head.raw_count;
   assign rsp_bus.eligible_count     = head.eligible_count;
   assign rsp_bus.reachable_count    = head.reachable_count;
   assign rsp_bus.unknown_count      = head.unknown_count;
   assign rsp_bus.last               = head.last;
endmodule

FILE: src/fcs_stencil.sv
// fcs_stencil: input register, raster counters, line buffer, 3x3 window and
// running totals. Depends on fcs_pkg, fcs_if and fcs_line_ram.
module fcs_stencil #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  fcs_pkg::cfg_type  cfg,
   fcs_req_if.sink           req_bus,
   input  logic              room_ok,
   output fcs_pkg::pair_type pair
);
   import fcs_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = XW + 1;
   localparam int YW = $clog2(MAX_HEIGHT) + 1;

   function automatic logic [2:0] classify(input logic [8:0] w, input logic [7:0] f,
                                          input logic eight);
      logic ring4, ring8, touch, fr, el, re;
      ring4 = w[1] | w[3] | w[5] | w[7];
      ring8 = ring4 | w[0] | w[2] | w[6] | w[8];
      touch = eight ? ring8 : ring4;
      fr    = f[1] & touch;
      el    = fr & ~f[2];
      re    = el & f[3];
      return {re, el, fr};
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] t,
                                               input logic [1:0] inc);
      logic [CNT_W:0] s;
      s = {1'b0, t} + {{(CNT_W - 1){1'b0}}, inc};
      if (s > {1'b0, CNT_MAX}) begin
         return CNT_MAX;
      end
      return s[CNT_W-1:0];
   endfunction

   logic             in_valid_ff, in_valid_in;
   item_type         in_item_ff, in_item_in;
   logic [XW-1:0]    col_ff, col_in;
   logic [YW-1:0]    row_ff, row_in;
   logic [8:0]       win_ff, win_in;
   logic [7:0]       flg_ff, flg_in;
   logic [CNT_W-1:0] raw_ff, raw_in;
   logic [CNT_W-1:0] elig_ff, elig_in;
   logic [CNT_W-1:0] rch_ff, rch_in;
   logic [CNT_W-1:0] unk_ff, unk_in;
   logic             rd_ok_ff;
   logic [XW-1:0]    rd_addr_ff;
   logic             fwd_ff, fwd_in;
   logic [4:0]       fwd_data_ff;

   logic [WW-1:0]    w_eff;
   logic [YW-1:0]    h_eff;
   logic [XW-1:0]    x, x_next, rd_addr;
   logic [YW-1:0]    y;
   logic             last_col, flush_row, process, take, accept;
   logic             y_ge1, y_ge2, va, vb;
   logic [4:0]       ram_q, line_data, wr_data;
   logic [3:0]       cur, mflags;
   logic             top, mid;
   logic [8:0]       w0, w1, w2;
   logic [7:0]       f0, f1, f2;
   logic [2:0]       cls_a, cls_b;
   logic             fa, ea, ra, fb, eb, rb;
   logic [CNT_W-1:0] raw_a, elig_a, rch_a, raw_b, elig_b, rch_b, unk_t;

   // effective map size
   always_comb begin
      if (cfg.map_width == '0) begin
         w_eff = WW'(1);
      end else if (int'(cfg.map_width) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(cfg.map_width);
      end
      if (cfg.map_height == '0) begin
         h_eff = YW'(1);
      end else if (int'(cfg.map_height) > MAX_HEIGHT) begin
         h_eff = YW'(MAX_HEIGHT);
      end else begin
         h_eff = YW'(cfg.map_height);
      end
   end

   assign x         = (WW'(col_ff) < w_eff) ? col_ff : XW'(w_eff - 1'b1);
   assign y         = (row_ff < h_eff) ? row_ff : h_eff;
   assign last_col  = (WW'(x) == w_eff - 1'b1);
   assign flush_row = (y == h_eff);
   assign x_next    = last_col ? '0 : x + 1'b1;
   assign y_ge1     = y != '0;
   assign y_ge2     = y >= YW'(2);

   assign process = in_valid_ff && rd_ok_ff && (rd_addr_ff == x) && room_ok;
   assign req_bus.ready = !in_valid_ff || process;
   assign accept  = req_bus.valid && req_bus.ready;

   assign rd_addr   = process ? x_next : x;
   assign line_data = fwd_ff ? fwd_data_ff : ram_q;
   assign mflags    = line_data[3:0];
   assign fwd_in    = process && (x_next == x);

   // classify the incoming cell: bit 0 unknown, 1 free, 2 inflated, 3 reachable
   assign take   = !flush_row && !in_item_ff.cmd;
   assign cur[0] = take & in_item_ff.occupancy[OCC_W-1];
   assign cur[1] = take & ~in_item_ff.occupancy[OCC_W-1]
                   & (in_item_ff.occupancy[OCC_W-2:0] <= cfg.free_threshold);
   assign cur[2] = take & in_item_ff.inflated;
   assign cur[3] = take & in_item_ff.reachable;

   assign top     = y_ge2 & line_data[4];
   assign mid     = y_ge1 & mflags[0];
   assign wr_data = {mflags[0], cur};

   fcs_line_ram #(
      .WIDTH (5),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (process),
      .wr_addr (x),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // window shift: new right column, then a blank column for the row end
   assign w0 = (x == '0) ? '0 : win_ff;
   assign f0 = (x == '0) ? '0 : flg_ff;
   assign w1 = ((w0 >> 1) & 9'h0DB) | {cur[0], 2'b00, mid, 2'b00, top, 2'b00};
   assign f1 = {(y_ge1 ? mflags : 4'h0), f0[7:4]};
   assign w2 = (w1 >> 1) & 9'h0DB;
   assign f2 = {4'h0, f1[7:4]};

   assign cls_a = classify(w1, f1, cfg.eight_connectivity);
   assign cls_b = classify(w2, f2, cfg.eight_connectivity);
   assign va    = y_ge1 && (x != '0);
   assign vb    = y_ge1 && last_col;
   assign fa    = va & cls_a[0];
   assign ea    = va & cls_a[1];
   assign ra    = va & cls_a[2];
   assign fb    = vb & cls_b[0];
   assign eb    = vb & cls_b[1];
   assign rb    = vb & cls_b[2];

   assign unk_t  = sat_add(unk_ff, {1'b0, cur[0]});
   assign raw_a  = sat_add(raw_ff, {1'b0, fa});
   assign elig_a = sat_add(elig_ff, {1'b0, ea});
   assign rch_a  = sat_add(rch_ff, {1'b0, ra});
   assign raw_b  = sat_add(raw_ff, {1'b0, fa} + {1'b0, fb});
   assign elig_b = sat_add(elig_ff, {1'b0, ea} + {1'b0, eb});
   assign rch_b  = sat_add(rch_ff, {1'b0, ra} + {1'b0, rb});

   always_comb begin
      pair.a_valid              = process & va;
      pair.b_valid              = process & vb;
      pair.a.cell_x             = COORD_W'(x - 1'b1);
      pair.a.cell_y             = COORD_W'(y - 1'b1);
      pair.a.frontier           = cls_a[0];
      pair.a.frontier_eligible  = cls_a[1];
      pair.a.frontier_reachable = cls_a[2];
      pair.a.raw_count          = raw_a;
      pair.a.eligible_count     = elig_a;
      pair.a.reachable_count    = rch_a;
      pair.a.unknown_count      = unk_t;
      pair.a.last               = 1'b0;
      pair.b.cell_x             = COORD_W'(w_eff - 1'b1);
      pair.b.cell_y             = COORD_W'(y - 1'b1);
      pair.b.frontier           = cls_b[0];
      pair.b.frontier_eligible  = cls_b[1];
      pair.b.frontier_reachable = cls_b[2];
      pair.b.raw_count          = raw_b;
      pair.b.eligible_count     = elig_b;
      pair.b.reachable_count    = rch_b;
      pair.b.unknown_count      = unk_t;
      pair.b.last               = flush_row;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      win_in      = win_ff;
      flg_in      = flg_ff;
      raw_in      = raw_ff;
      elig_in     = elig_ff;
      rch_in      = rch_ff;
      unk_in      = unk_ff;
      if (process) begin
         in_valid_in = 1'b0;
         if (last_col && flush_row) begin
            // end of map: back to the start state
            col_in  = '0;
            row_in  = '0;
            win_in  = '0;
            flg_in  = '0;
            raw_in  = '0;
            elig_in = '0;
            rch_in  = '0;
            unk_in  = '0;
         end else begin
            col_in  = x_next;
            row_in  = last_col ? y + 1'b1 : y;
            win_in  = w1;
            flg_in  = f1;
            raw_in  = raw_b;
            elig_in = elig_b;
            rch_in  = rch_b;
            unk_in  = unk_t;
         end
      end
      if (accept) begin
         in_valid_in          = 1'b1;
         in_item_in.cmd       = req_bus.cmd;
         in_item_in.occupancy = req_bus.occupancy;
         in_item_in.inflated  = req_bus.inflated;
         in_item_in.reachable = req_bus.reachable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
         win_ff      <= '0;
         flg_ff      <= '0;
         raw_ff      <= '0;
         elig_ff     <= '0;
         rch_ff      <= '0;
         unk_ff      <= '0;
         rd_ok_ff    <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         win_ff      <= win_in;
         flg_ff      <= flg_in;
         raw_ff      <= raw_in;
         elig_ff     <= elig_in;
         rch_ff      <= rch_in;
         unk_ff      <= unk_in;
         rd_ok_ff    <= 1'b1;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rd_addr_ff  <= rd_addr;
      fwd_data_ff <= wr_data;
   end
endmodule

FILE: src/frontier_cell_stencil_core.sv
// frontier_cell_stencil_core: top level of the 3x3 frontier stencil.
// Holds the configuration registers; depends on fcs_pkg, fcs_if, fcs_stencil
// and fcs_result_queue.
//
// Usage: occupancy cells enter on req_bus in raster order, one transaction
// per cell; after the last map row send one row of flush transactions
// (cmd = 1). Each classified cell leaves as one transaction on rsp_bus, one
// row and one column behind the input; the last column of every row gives
// two results, so rsp_bus carries width results per width cells, none
// for the first input row. Results carry running totals; the result with
// last set closes the map and the block then starts a fresh map.
// An accepted cell passes the input register and the result queue on its way to rsp_bus.
// Throughput: one cell per cycle, set by the single line-buffer RAM read
// port; req_bus pauses when the four-entry result queue cannot take a row-end
// pair, and also after reset and any size change while the line buffer read
// is refetched.
// Reset clears counters, window and totals and loads the default sizes.
// A stalled rsp_bus fills the queue and then holds req_bus ready low.
// Registers on csr_bus are to be written only while the block is idle; the block does not enforce this.
module frontier_cell_stencil_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic      clock,
   input  logic      reset,
   fcs_req_if.sink   req_bus,
   fcs_rsp_if.source rsp_bus,
   fcs_csr_if.sink   csr_bus
);
   import fcs_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   pair_type pair;
   logic     room_ok;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            REG_MAP_WIDTH: begin
               cfg_in.map_width = csr_bus.data[SIZE_W-1:0];
            end
            REG_MAP_HEIGHT: begin
               cfg_in.map_height = csr_bus.data[SIZE_W-1:0];
            end
            REG_FREE_THR: begin
               cfg_in.free_threshold = csr_bus.data[THR_W-1:0];
            end
            REG_EIGHT_CONN: begin
               cfg_in.eight_connectivity = csr_bus.data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_width          <= MAP_WIDTH_RESET;
         cfg_ff.map_height         <= MAP_HEIGHT_RESET;
         cfg_ff.free_threshold     <= FREE_THR_RESET;
         cfg_ff.eight_connectivity <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fcs_stencil #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_stencil (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req_bus (req_bus),
      .room_ok (room_ok),
      .pair    (pair)
   );

   fcs_result_queue u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .pair    (pair),
      .room_ok (room_ok),
      .rsp_bus (rsp_bus)
   );
endmodule

FILE: dv/tb_frontier_cell_stencil_core.sv
// tb_frontier_cell_stencil_core: checks the 3x3 frontier stencil against its own line-buffer
// predictor over directed maps, extreme sizes and random maps under varied back-pressure.
// Depends on fcs_pkg, fcs_if and frontier_cell_stencil_core.
`timescale 1ns / 100ps

module tb_frontier_cell_stencil_core;
   import fcs_pkg::*;

   localparam int MAP_COLS_MAX  = 1024;
   localparam int MAP_ROWS_MAX  = 1024;
   localparam int RANDOM_ITEMS  = 950;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_REPORTS   = 10;

   localparam logic CMD_CELL  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam int FLAG_UNKNOWN  = 0;
   localparam int FLAG_FREE     = 1;
   localparam int FLAG_INFLATED = 2;
   localparam int FLAG_REACH    = 3;

   localparam int TALLY_RAW      = 0;
   localparam int TALLY_ELIGIBLE = 1;
   localparam int TALLY_REACH    = 2;
   localparam int TALLY_UNKNOWN  = 3;

   logic clock;
   logic reset;

   fcs_req_if req_bus ();
   fcs_rsp_if rsp_bus ();
   fcs_csr_if csr_bus ();

   frontier_cell_stencil_core #(
      .MAX_WIDTH  (MAP_COLS_MAX),
      .MAX_HEIGHT (MAP_ROWS_MAX)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   cfg_type          map_cfg;
   bit               upper_unknown_line [MAP_COLS_MAX];
   bit [3:0]         middle_flag_line [MAP_COLS_MAX];
   bit [8:0]         window_unk_bits;
   bit [7:0]         centre_flags;
   int unsigned      next_col;
   int unsigned      next_row;
   bit [CNT_W-1:0]   tally [4];
   result_type       expected_cells [$];

   int               fail_count;
   int unsigned      cells_sent;
   int unsigned      req_idle_pct;
   int unsigned      rsp_stall_pct;

   always #6 clock = ~clock;

   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int unsigned map_cols();
      int unsigned w;
      w = map_cfg.map_width;
      if (w < 1) w = 1;
      if (w > MAP_COLS_MAX) w = MAP_COLS_MAX;
      return w;
   endfunction

   function automatic int unsigned map_rows();
      int unsigned h;
      h = map_cfg.map_height;
      if (h < 1) h = 1;
      if (h > MAP_ROWS_MAX) h = MAP_ROWS_MAX;
      return h;
   endfunction

   function automatic void bump_tally(int k);
      if (tally[k] != CNT_MAX) tally[k]++;
   endfunction

   function automatic void slide_window(bit top, bit mid, bit bot, bit [3:0] rflags);
      window_unk_bits = ((window_unk_bits >> 1) & 9'h0DB) | {bot, 2'b00, mid, 2'b00, top, 2'b00};
      centre_flags = {rflags, centre_flags[7:4]};
   endfunction

   function automatic void classify_centre(int unsigned cx, int unsigned cy, bit is_last);
      bit [3:0]   c;
      bit         ring4, ring8, touch, fr, el, re;
      result_type r;
      c = centre_flags[3:0];
      ring4 = window_unk_bits[1] | window_unk_bits[3] | window_unk_bits[5] | window_unk_bits[7];
      ring8 = ring4 | window_unk_bits[0] | window_unk_bits[2] | window_unk_bits[6]
              | window_unk_bits[8];
      touch = map_cfg.eight_connectivity ? ring8 : ring4;
      fr = c[FLAG_FREE] & touch;
      el = fr & ~c[FLAG_INFLATED];
      re = el & c[FLAG_REACH];
      if (fr) bump_tally(TALLY_RAW);
      if (el) bump_tally(TALLY_ELIGIBLE);
      if (re) bump_tally(TALLY_REACH);
      r.cell_x             = cx[COORD_W-1:0];
      r.cell_y             = cy[COORD_W-1:0];
      r.frontier           = fr;
      r.frontier_eligible  = el;
      r.frontier_reachable = re;
      r.raw_count          = tally[TALLY_RAW];
      r.eligible_count     = tally[TALLY_ELIGIBLE];
      r.reachable_count    = tally[TALLY_REACH];
      r.unknown_count      = tally[TALLY_UNKNOWN];
      r.last               = is_last;
      expected_cells.push_back(r);
   endfunction

   function automatic void step_stencil(item_type it);
      int unsigned cols, rows, x, y;
      int          occ;
      bit [3:0]    cur, mflags;
      bit          top, mid;
      cols = map_cols();
      rows = map_rows();
      x = (next_col < cols) ? next_col : cols - 1;
      y = (next_row < rows) ? next_row : rows;
      cur = '0;
      occ = $signed(it.occupancy);
      if (y < rows && it.cmd == CMD_CELL) begin
         if (occ < 0) begin
            cur[FLAG_UNKNOWN] = 1'b1;
            bump_tally(TALLY_UNKNOWN);
         end
         if (occ >= 0 && occ <= int'(map_cfg.free_threshold)) cur[FLAG_FREE] = 1'b1;
         cur[FLAG_INFLATED] = it.inflated;
         cur[FLAG_REACH]    = it.reachable;
      end
      mflags = middle_flag_line[x];
      top = (y >= 2) ? upper_unknown_line[x] : 1'b0;
      mid = (y >= 1) ? mflags[FLAG_UNKNOWN] : 1'b0;
      upper_unknown_line[x] = mflags[FLAG_UNKNOWN];
      middle_flag_line[x] = cur;
      if (x == 0) begin
         window_unk_bits = '0;
         centre_flags = '0;
      end
      slide_window(top, mid, cur[FLAG_UNKNOWN], (y >= 1) ? mflags : 4'h0);
      if (y >= 1 && x >= 1) classify_centre(x - 1, y - 1, 1'b0);
      if (y >= 1 && x == cols - 1) begin
         slide_window(1'b0, 1'b0, 1'b0, 4'h0);
         classify_centre(cols - 1, y - 1, y == rows);
      end
      if (y == rows && x == cols - 1) begin
         next_col = 0;
         next_row = 0;
         window_unk_bits = '0;
         centre_flags = '0;
         tally = '{default: '0};
      end else if (x == cols - 1) begin
         next_col = 0;
         next_row = y + 1;
      end else begin
         next_col = x + 1;
         next_row = y;
      end
   endfunction

   function automatic string show_cell(result_type r);
      return $sformatf("(%0d,%0d) f%b e%b r%b raw %0d elig %0d reach %0d unk %0d last %b",
                       r.cell_x, r.cell_y, r.frontier, r.frontier_eligible,
                       r.frontier_reachable, r.raw_count, r.eligible_count,
                       r.reachable_count, r.unknown_count, r.last);
   endfunction

   function automatic item_type make_item(bit cmd, int occ, bit infl, bit reach);
      item_type it;
      it.cmd       = cmd;
      it.occupancy = occ[OCC_W-1:0];
      it.inflated  = infl;
      it.reachable = reach;
      return it;
   endfunction

   function automatic item_type random_cell();
      item_type it;
      it.cmd = CMD_CELL;
      case ($urandom_range(2))
         0: it.occupancy = OCC_W'($urandom_range(255, 128));
         1: it.occupancy = OCC_W'($urandom_range(map_cfg.free_threshold, 0));
         default: it.occupancy = OCC_W'($urandom_range(255));
      endcase
      it.inflated  = 1'($urandom_range(1));
      it.reachable = 1'($urandom_range(1));
      return it;
   endfunction

   // check results first, then advance the predictor on accepted cells and writes
   always @(posedge clock) begin : monitor
      result_type seen, want;
      item_type   it;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.cell_x             = rsp_bus.cell_x;
            seen.cell_y             = rsp_bus.cell_y;
            seen.frontier           = rsp_bus.frontier;
            seen.frontier_eligible  = rsp_bus.frontier_eligible;
            seen.frontier_reachable = rsp_bus.frontier_reachable;
            seen.raw_count          = rsp_bus.raw_count;
            seen.eligible_count     = rsp_bus.eligible_count;
            seen.reachable_count    = rsp_bus.reachable_count;
            seen.unknown_count      = rsp_bus.unknown_count;
            seen.last               = rsp_bus.last;
            if (expected_cells.size() == 0) begin
               if (fail_count < MAX_REPORTS)
                  $display("unexpected result %s", show_cell(seen));
               fail_count++;
            end else begin
               want = expected_cells.pop_front();
               if (seen !== want) begin
                  if (fail_count < MAX_REPORTS)
                     $display("mismatch: expected %s, got %s", show_cell(want), show_cell(seen));
                  fail_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            it.cmd       = req_bus.cmd;
            it.occupancy = req_bus.occupancy;
            it.inflated  = req_bus.inflated;
            it.reachable = req_bus.reachable;
            step_stencil(it);
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_MAP_WIDTH:  map_cfg.map_width = csr_bus.data[SIZE_W-1:0];
               REG_MAP_HEIGHT: map_cfg.map_height = csr_bus.data[SIZE_W-1:0];
               REG_FREE_THR:   map_cfg.free_threshold = csr_bus.data[THR_W-1:0];
               REG_EIGHT_CONN: map_cfg.eight_connectivity = csr_bus.data[0];
               default: ;
            endcase
         end
      end
   end

   always @(negedge clock) rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);

   task automatic send_cell(item_type it);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= it.cmd;
      req_bus.occupancy <= it.occupancy;
      req_bus.inflated  <= it.inflated;
      req_bus.reachable <= it.reachable;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      cells_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_cells.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_map(int w, int h, int thr, int eight);
      wait_drained();
      write_reg(REG_MAP_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_MAP_HEIGHT, CSR_DATA_W'(h));
      write_reg(REG_FREE_THR, CSR_DATA_W'(thr));
      write_reg(REG_EIGHT_CONN, CSR_DATA_W'(eight));
      csr_bus.valid <= 1'b0;
   endtask

   // send until the map closes; noise is flush items in map rows and cells in the flush row
   task automatic run_map(int unsigned noise_pct);
      item_type it;
      do begin
         if (next_row >= map_rows())
            it = ($urandom_range(99) < noise_pct) ? random_cell() : make_item(CMD_FLUSH, 0, 0, 0);
         else
            it = ($urandom_range(99) < noise_pct) ? make_item(CMD_FLUSH, 0, 0, 0) : random_cell();
         send_cell(it);
      end while (next_col != 0 || next_row != 0);
   endtask

   task automatic test_stencil_extremes();
      program_map(3, 3, 25, 1);
      send_cell(make_item(CMD_CELL, -128, 0, 0));
      send_cell(make_item(CMD_CELL, 0, 0, 1));
      send_cell(make_item(CMD_CELL, 127, 1, 1));
      send_cell(make_item(CMD_CELL, 25, 0, 1));
      send_cell(make_item(CMD_CELL, 26, 0, 0));
      send_cell(make_item(CMD_FLUSH, 0, 0, 0));
      send_cell(make_item(CMD_CELL, -1, 1, 0));
      send_cell(make_item(CMD_CELL, 0, 1, 1));
      send_cell(make_item(CMD_CELL, 100, 0, 1));
      send_cell(make_item(CMD_FLUSH, 0, 0, 0));
      send_cell(make_item(CMD_CELL, -5, 1, 1));
      send_cell(make_item(CMD_FLUSH, 0, 0, 0));
   endtask

   task automatic test_four_neighbours();
      program_map(2, 2, 0, 0);
      send_cell(make_item(CMD_CELL, 0, 0, 1));
      send_cell(make_item(CMD_CELL, 100, 0, 0));
      send_cell(make_item(CMD_CELL, 1, 0, 1));
      send_cell(make_item(CMD_CELL, -1, 0, 0));
      send_cell(make_item(CMD_FLUSH, 0, 0, 0));
      send_cell(make_item(CMD_FLUSH, 0, 0, 0));
   endtask

   task automatic test_degenerate_sizes();
      program_map(0, 0, 99, 1);
      send_cell(make_item(CMD_CELL, 99, 0, 1));
      send_cell(make_item(CMD_FLUSH, 0, 0, 0));
   endtask

   task automatic test_resize_mid_map();
      program_map(4, 4, 50, 1);
      repeat (10) send_cell(random_cell());
      wait_drained();
      write_reg(REG_MAP_WIDTH, CSR_DATA_W'(2));
      write_reg(REG_MAP_HEIGHT, CSR_DATA_W'(1));
      csr_bus.valid <= 1'b0;
      run_map(0);
   endtask

   task automatic test_widest_row();
      req_idle_pct  = 11;
      rsp_stall_pct = 11;
      program_map(2047, 1, 99, 0);
      run_map(2);
   endtask

   task automatic test_tallest_column();
      req_idle_pct  = 0;
      rsp_stall_pct = 60;
      program_map(1, 1100, 0, 1);
      run_map(2);
   endtask

   task automatic test_random_maps();
      int unsigned first, map_no;
      int          w, h, thr;
      first  = cells_sent;
      map_no = 0;
      while (cells_sent - first < RANDOM_ITEMS) begin
         case (map_no % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 60; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 60; end
            default: begin req_idle_pct = 11; rsp_stall_pct = 11; end
         endcase
         w = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         h = ($urandom_range(7) == 0) ? $urandom_range(14, 7) : $urandom_range(6, 1);
         case ($urandom_range(3))
            0: thr = 0;
            1: thr = 99;
            default: thr = $urandom_range(99);
         endcase
         program_map(w, h, thr, $urandom_range(1));
         run_map(4);
         map_no++;
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_CELL;
      req_bus.occupancy = '0;
      req_bus.inflated  = 1'b0;
      req_bus.reachable = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = REG_MAP_WIDTH;
      csr_bus.data      = '0;
      rsp_bus.ready     = 1'b0;
      map_cfg = '{MAP_WIDTH_RESET, MAP_HEIGHT_RESET, FREE_THR_RESET, 1'b1};
      window_unk_bits = '0;
      centre_flags = '0;
      next_col = 0;
      next_row = 0;
      tally = '{default: '0};
      fail_count = 0;
      cells_sent = 0;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_stencil_extremes();
      test_four_neighbours();
      test_degenerate_sizes();
      test_resize_mid_map();
      test_widest_row();
      test_tallest_column();
      test_random_maps();

      wait_drained();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
